// File: rtl/core/bota_pkg.sv
// Shared types and constants for the box overlap track associator.
package bota_pkg;

   // Default capacity of one frame bank
   localparam int MAX_BOXES = 16;
   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   // Coordinate, identity and age widths
   localparam int COORD_W = 12;
   localparam int ID_W = 11;
   localparam int AGE_W = 16;
   // Identity meaning "unknown"
   localparam logic signed [ID_W-1:0] ID_NONE = 11'h7FF;
   // Saturation value of the age counter
   localparam logic [AGE_W-1:0] AGE_MAX = 16'hFFFF;

   // Command handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0]        box_left;
      logic [COORD_W-1:0]        box_top;
      logic [COORD_W-1:0]        box_right;
      logic [COORD_W-1:0]        box_bottom;
      logic signed [ID_W-1:0]    recognized_id;
      logic                      is_box;
      logic                      frame_end;
   } cmd_type;

   // One stored entry of a frame bank
   typedef struct packed {
      logic [COORD_W-1:0]        box_left;
      logic [COORD_W-1:0]        box_top;
      logic [COORD_W-1:0]        box_right;
      logic [COORD_W-1:0]        box_bottom;
      logic signed [ID_W-1:0]    identity;
      logic [AGE_W-1:0]          age;
   } entry_type;

endpackage

// File: rtl/core/bota_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bota_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bota_front.sv
// Front end: takes input transfers, holds enable, classifies items into commands.
module bota_front #(
   parameter int MAX_BOXES = bota_pkg::MAX_BOXES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_enable,
   // input channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_left,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_top,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_right,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_bottom,
   input  logic signed [bota_pkg::ID_W-1:0]      req_recognized_id,
   input  logic                                  req_has_box,
   input  logic                                  req_frame_end,
   // queue side
   output logic                                  push,
   output bota_pkg::cmd_type                     push_cmd,
   input  logic                                  queue_full
);

   localparam int CW = $clog2(MAX_BOXES + 1);

   logic          enable_ff, enable_in;
   logic [CW-1:0] count_ff, count_in;
   logic          accept;
   logic          is_box;

   assign csr_ready = 1'b1;
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign is_box    = req_has_box && (count_ff < CW'(MAX_BOXES));

   // Command build; dropped boxes only pass on their frame close
   assign push = accept && enable_ff && (is_box || req_frame_end);
   always_comb begin
      push_cmd.box_left      = req_box_left;
      push_cmd.box_top       = req_box_top;
      push_cmd.box_right     = req_box_right;
      push_cmd.box_bottom    = req_box_bottom;
      push_cmd.recognized_id = req_recognized_id;
      push_cmd.is_box        = is_box;
      push_cmd.frame_end     = req_frame_end;
   end

   // Enable register and per-frame box count
   always_comb begin
      enable_in = enable_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         enable_in = csr_enable;
      end
      if (accept && enable_ff) begin
         if (req_frame_end) begin
            count_in = '0;
         end else if (is_box) begin
            count_in = count_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         enable_ff <= enable_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/bota_queue.sv
// Short command queue decoupling the front end from the back end.
module bota_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bota_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output bota_pkg::cmd_type head_cmd
);

   localparam int DEPTH = bota_pkg::QUEUE_DEPTH;
   localparam int PW = $clog2(DEPTH);

   bota_pkg::cmd_type slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full       = (fill_ff == (PW+1)'(DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_cmd   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   fill_in = fill_ff + (PW+1)'(1);
         2'b01:   fill_in = fill_ff - (PW+1)'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/bota_back.sv
// Back end: scans the previous frame bank, assigns identity and age, drives results.
module bota_back #(
   parameter int MAX_BOXES = bota_pkg::MAX_BOXES
) (
   input  logic                             clock,
   input  logic                             reset,
   // queue side
   input  logic                             head_valid,
   input  bota_pkg::cmd_type                head_cmd,
   output logic                             pop,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic signed [bota_pkg::ID_W-1:0] rsp_identity,
   output logic                             rsp_inherited,
   output logic [bota_pkg::AGE_W-1:0]       rsp_age
);

   localparam int CW = $clog2(MAX_BOXES + 1);
   localparam int AW = $clog2(2 * MAX_BOXES);
   localparam int EW = $bits(bota_pkg::entry_type);
   localparam int XW = bota_pkg::COORD_W;
   localparam int PW = 2 * XW;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DECIDE = 5'b00100,
      ST_AGE    = 5'b01000,
      ST_WRITE  = 5'b10000
   } state_type;

   // Positive extent of two intervals
   function automatic logic [XW-1:0] span(input logic [XW-1:0] lo_a, input logic [XW-1:0] hi_a,
                                          input logic [XW-1:0] lo_b, input logic [XW-1:0] hi_b);
      logic [XW-1:0] lo;
      logic [XW-1:0] hi;
      lo = (lo_a > lo_b) ? lo_a : lo_b;
      hi = (hi_a < hi_b) ? hi_a : hi_b;
      return (hi > lo) ? hi - lo : '0;
   endfunction

   state_type                state_ff, state_in;
   bota_pkg::cmd_type        cmd_ff, cmd_in;
   logic [XW-1:0]            own_w_ff, own_w_in, own_h_ff, own_h_in;
   logic [PW-3:0]            own_q_ff, own_q_in;
   logic [CW-1:0]            rd_k_ff, rd_k_in;
   logic                     v1_ff, v1_in, v2_ff, v2_in;
   logic [XW-1:0]            ov_w_ff, ov_w_in, ov_h_ff, ov_h_in;
   logic signed [bota_pkg::ID_W-1:0] ov_id_ff, ov_id_in;
   logic [PW-1:0]            best_ff, best_in;
   logic signed [bota_pkg::ID_W-1:0] best_id_ff, best_id_in;
   logic signed [bota_pkg::ID_W-1:0] id_ff, id_in;
   logic                     inh_ff, inh_in;
   logic                     found_ff, found_in;
   logic [bota_pkg::AGE_W-1:0] age_ff, age_in;
   logic [CW-1:0]            prev_count_ff, prev_count_in;
   logic [CW-1:0]            wr_count_ff, wr_count_in;
   logic                     bank_ff, bank_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [bota_pkg::ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                     rsp_inh_ff, rsp_inh_in;
   logic [bota_pkg::AGE_W-1:0] rsp_age_ff, rsp_age_in;

   logic                     rd_en, wr_en, out_free, rd_more;
   logic [AW-1:0]            prev_base, cur_base, rd_addr, wr_addr;
   logic [EW-1:0]            rd_data;
   bota_pkg::entry_type      rd_entry, wr_entry;
   logic [PW-1:0]            ov_area, own_area;
   logic [CW-1:0]            cnt_next;

   // Entry memory: two banks of MAX_BOXES entries
   bota_ram #(
      .WIDTH(EW),
      .DEPTH(2 * MAX_BOXES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rd_entry  = bota_pkg::entry_type'(rd_data);
   assign prev_base = bank_ff ? '0 : AW'(MAX_BOXES);
   assign cur_base  = bank_ff ? AW'(MAX_BOXES) : '0;
   assign rd_addr   = prev_base + AW'(rd_k_ff);
   assign wr_addr   = cur_base + AW'(wr_count_ff);
   assign rd_more   = (rd_k_ff < prev_count_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == ST_IDLE) && head_valid;
   assign cnt_next  = wr_count_ff + CW'(1);

   // Read issue during both scans; age scan stops at first match
   assign rd_en = rd_more && ((state_ff == ST_SCAN) || ((state_ff == ST_AGE) && !found_ff));

   // Multipliers: candidate overlap and own area
   assign ov_area  = ov_w_ff * ov_h_ff;
   assign own_area = own_w_ff * own_h_ff;

   always_comb begin
      wr_entry.box_left   = cmd_ff.box_left;
      wr_entry.box_top    = cmd_ff.box_top;
      wr_entry.box_right  = cmd_ff.box_right;
      wr_entry.box_bottom = cmd_ff.box_bottom;
      wr_entry.identity   = id_ff;
      wr_entry.age        = age_ff;
   end

   // Sequencer and scan pipeline
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      own_w_in      = own_w_ff;
      own_h_in      = own_h_ff;
      own_q_in      = own_q_ff;
      rd_k_in       = rd_k_ff;
      v1_in         = rd_en;
      v2_in         = v1_ff && (state_ff == ST_SCAN);
      ov_w_in       = span(cmd_ff.box_left, cmd_ff.box_right,
                           rd_entry.box_left, rd_entry.box_right);
      ov_h_in       = span(cmd_ff.box_top, cmd_ff.box_bottom,
                           rd_entry.box_top, rd_entry.box_bottom);
      ov_id_in      = rd_entry.identity;
      best_in       = best_ff;
      best_id_in    = best_id_ff;
      id_in         = id_ff;
      inh_in        = inh_ff;
      found_in      = found_ff;
      age_in        = age_ff;
      prev_count_in = prev_count_ff;
      wr_count_in   = wr_count_ff;
      bank_in       = bank_ff;
      wr_en         = 1'b0;
      rsp_id_in     = rsp_id_ff;
      rsp_inh_in    = rsp_inh_ff;
      rsp_age_in    = rsp_age_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (rd_en) begin
         rd_k_in = rd_k_ff + CW'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               cmd_in   = head_cmd;
               own_w_in = span(head_cmd.box_left, head_cmd.box_right,
                               head_cmd.box_left, head_cmd.box_right);
               own_h_in = span(head_cmd.box_top, head_cmd.box_bottom,
                               head_cmd.box_top, head_cmd.box_bottom);
               rd_k_in  = '0;
               best_in  = '0;
               if (head_cmd.is_box) begin
                  state_in = ST_SCAN;
               end else begin
                  // marker or dropped box closing the frame
                  prev_count_in = wr_count_ff;
                  wr_count_in   = '0;
                  bank_in       = !bank_ff;
               end
            end
         end
         ST_SCAN: begin
            own_q_in = own_area[PW-1:2];
            // strict compare keeps the earliest of equal overlaps
            if (v2_ff && (ov_area > best_ff)) begin
               best_in    = ov_area;
               best_id_in = ov_id_ff;
            end
            if (!rd_more && !v1_ff && !v2_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            id_in  = bota_pkg::ID_NONE;
            inh_in = 1'b0;
            if (best_ff > PW'(own_q_ff)) begin
               id_in  = best_id_ff;
               inh_in = 1'b1;
            end
            if (!cmd_ff.recognized_id[bota_pkg::ID_W-1]) begin
               id_in = cmd_ff.recognized_id;
            end
            rd_k_in  = '0;
            found_in = 1'b0;
            age_in   = '0;
            state_in = ST_AGE;
         end
         ST_AGE: begin
            if (v1_ff && !found_ff && (rd_entry.identity == id_ff)) begin
               found_in = 1'b1;
               age_in   = (rd_entry.age == bota_pkg::AGE_MAX) ?
                          rd_entry.age : rd_entry.age + bota_pkg::AGE_W'(1);
            end
            if (found_ff || (!rd_more && !v1_ff)) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_inh_in   = inh_ff;
               rsp_age_in   = age_ff;
               if (cmd_ff.frame_end) begin
                  prev_count_in = cnt_next;
                  wr_count_in   = '0;
                  bank_in       = !bank_ff;
               end else begin
                  wr_count_in = cnt_next;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_k_ff       <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         found_ff      <= 1'b0;
         prev_count_ff <= '0;
         wr_count_ff   <= '0;
         bank_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_k_ff       <= rd_k_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         found_ff      <= found_in;
         prev_count_ff <= prev_count_in;
         wr_count_ff   <= wr_count_in;
         bank_ff       <= bank_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      own_w_ff   <= own_w_in;
      own_h_ff   <= own_h_in;
      own_q_ff   <= own_q_in;
      ov_w_ff    <= ov_w_in;
      ov_h_ff    <= ov_h_in;
      ov_id_ff   <= ov_id_in;
      best_ff    <= best_in;
      best_id_ff <= best_id_in;
      id_ff      <= id_in;
      inh_ff     <= inh_in;
      age_ff     <= age_in;
      rsp_id_ff  <= rsp_id_in;
      rsp_inh_ff <= rsp_inh_in;
      rsp_age_ff <= rsp_age_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_identity  = rsp_id_ff;
   assign rsp_inherited = rsp_inh_ff;
   assign rsp_age       = rsp_age_ff;

endmodule

// File: rtl/core/box_overlap_track_associator.sv
// Top level of the box overlap track associator.
//
// Usage: detected boxes of a frame arrive one per req_ transfer; req_frame_end
// closes the frame after that item. Each box with req_has_box set yields one
// rsp_ transfer with its identity, inherited flag and age; markers and boxes
// past MAX_BOXES in a frame yield none. csr_enable (written through csr_valid,
// always ready) gates everything: while it is low, items are taken and dropped.
// The front takes an item per cycle, while the queue is not full, into a four-entry
// command queue. The back handles one command at a time; the single read port of
// the entry memory is scanned once for the best overlap and once for the age
// lookup, and the age lookup ends early on its first hit.
// Reset clears enable, the queue, the frame counts and the bank select; the
// entry memory is not cleared, and only entries written in the previous frame
// are read. When the receiver stalls, the result is held in the output
// register, the back waits, and the queue fills until req_stall rises.
module box_overlap_track_associator #(
   parameter int MAX_BOXES = bota_pkg::MAX_BOXES
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic                                  csr_enable,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_left,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_top,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_right,
   input  logic [bota_pkg::COORD_W-1:0]          req_box_bottom,
   input  logic signed [bota_pkg::ID_W-1:0]      req_recognized_id,
   input  logic                                  req_has_box,
   input  logic                                  req_frame_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bota_pkg::ID_W-1:0]      rsp_identity,
   output logic                                  rsp_inherited,
   output logic [bota_pkg::AGE_W-1:0]            rsp_age
);

   logic              push, queue_full, pop, head_valid;
   bota_pkg::cmd_type push_cmd, head_cmd;

   // Front: input transfers and classification
   bota_front #(
      .MAX_BOXES(MAX_BOXES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_enable       (csr_enable),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_right    (req_box_right),
      .req_box_bottom   (req_box_bottom),
      .req_recognized_id(req_recognized_id),
      .req_has_box      (req_has_box),
      .req_frame_end    (req_frame_end),
      .push             (push),
      .push_cmd         (push_cmd),
      .queue_full       (queue_full)
   );

   // Command queue
   bota_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .head_valid(head_valid),
      .head_cmd  (head_cmd)
   );

   // Back: association and result delivery
   bota_back #(
      .MAX_BOXES(MAX_BOXES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_cmd     (head_cmd),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_identity (rsp_identity),
      .rsp_inherited(rsp_inherited),
      .rsp_age      (rsp_age)
   );

endmodule

// File: rtl/core/bota_checker.sv
// Port-level checker for the box overlap track associator, bound to the top level.
module bota_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [bota_pkg::ID_W-1:0]      rsp_identity,
   input logic                                  rsp_inherited,
   input logic [bota_pkg::AGE_W-1:0]            rsp_age
);

   // A stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_identity) && $stable(rsp_inherited)
                                 && $stable(rsp_age))
      else $error("stalled result payload changed");

   // Reset empties the output register and the queue
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output or queue not empty after reset");

   // The only negative identity ever assigned is unknown
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_identity[bota_pkg::ID_W-1] |-> rsp_identity == bota_pkg::ID_NONE)
      else $error("negative identity other than unknown");

endmodule

bind box_overlap_track_associator bota_checker u_checker (.*);

// File: test/tb_box_overlap_track_associator.sv
// Self-checking testbench for the box overlap track associator.
module tb_box_overlap_track_associator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP = bota_pkg::MAX_BOXES;
   localparam int CW = bota_pkg::COORD_W;
   localparam int IW = bota_pkg::ID_W;
   localparam int AW = bota_pkg::AGE_W;
   localparam int AREA_DIV = 4;
   localparam int COORD_MAX = (1 << CW) - 1;
   localparam int SETTLE_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;
   localparam int LONG_HOLD = 300;

   // one detection transfer
   typedef struct packed {
      logic [CW-1:0]        left;
      logic [CW-1:0]        top;
      logic [CW-1:0]        right;
      logic [CW-1:0]        bottom;
      logic signed [IW-1:0] rec_id;
      logic                 has_box;
      logic                 frame_end;
   } det_item_type;

   // one track result transfer
   typedef struct packed {
      logic signed [IW-1:0] identity;
      logic                 inherited;
      logic [AW-1:0]        age;
   } track_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_enable;
   logic                 req_valid;
   logic                 req_stall;
   logic [CW-1:0]        req_box_left;
   logic [CW-1:0]        req_box_top;
   logic [CW-1:0]        req_box_right;
   logic [CW-1:0]        req_box_bottom;
   logic signed [IW-1:0] req_recognized_id;
   logic                 req_has_box;
   logic                 req_frame_end;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [IW-1:0] rsp_identity;
   logic                 rsp_inherited;
   logic [AW-1:0]        rsp_age;

   box_overlap_track_associator u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_enable        (csr_enable),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_box_left      (req_box_left),
      .req_box_top       (req_box_top),
      .req_box_right     (req_box_right),
      .req_box_bottom    (req_box_bottom),
      .req_recognized_id (req_recognized_id),
      .req_has_box       (req_has_box),
      .req_frame_end     (req_frame_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_identity      (rsp_identity),
      .rsp_inherited     (rsp_inherited),
      .rsp_age           (rsp_age)
   );

   // tracker state mirrored by the predictor: two banks of entries
   logic [CW-1:0]        bank_left   [2][CAP];
   logic [CW-1:0]        bank_top    [2][CAP];
   logic [CW-1:0]        bank_right  [2][CAP];
   logic [CW-1:0]        bank_bottom [2][CAP];
   logic signed [IW-1:0] bank_id     [2][CAP];
   logic [AW-1:0]        bank_age    [2][CAP];
   int                   prior_count = 0;
   int                   fill_count = 0;
   bit                   fill_bank = 1'b0;
   bit                   track_enable = 1'b0;

   track_type            expected_tracks[$];
   det_item_type         prior_frame[$];
   det_item_type         current_frame[$];
   int                   fail_count = 0;
   int                   idle_cycles = 0;
   bit                   quiet_mode = 1'b0;
   int                   rsp_hold_len = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic log_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("%0t: %s", $realtime, msg);
   endtask

   // overlap of two intervals, zero when they do not cross
   function automatic int span(input int lo_a, input int hi_a, input int lo_b, input int hi_b);
      int lo;
      int hi;
      lo = (lo_a > lo_b) ? lo_a : lo_b;
      hi = (hi_a < hi_b) ? hi_a : hi_b;
      return (hi > lo) ? hi - lo : 0;
   endfunction

   // predict the track result of one accepted detection
   function automatic void predict_track(input det_item_type it);
      int                   own;
      int                   best;
      int                   best_k;
      int                   area;
      int                   pb;
      int                   cb;
      bit                   found;
      logic signed [IW-1:0] id;
      logic                 inh;
      logic [AW-1:0]        age;
      track_type            trk;
      if (!track_enable)
         return;
      if (it.has_box && fill_count < CAP) begin
         cb = int'(fill_bank);
         pb = 1 - cb;
         own = span(it.left, it.right, it.left, it.right) *
               span(it.top, it.bottom, it.top, it.bottom);
         best = 0;
         best_k = 0;
         for (int k = 0; k < prior_count; k++) begin
            area = span(it.left, it.right, bank_left[pb][k], bank_right[pb][k]) *
                   span(it.top, it.bottom, bank_top[pb][k], bank_bottom[pb][k]);
            if (area > best) begin
               best = area;
               best_k = k;
            end
         end
         id = bota_pkg::ID_NONE;
         inh = 1'b0;
         if (best > own / AREA_DIV) begin
            id = bank_id[pb][best_k];
            inh = 1'b1;
         end
         // a recognizer identity overrides the overlap choice
         if (!it.rec_id[IW-1])
            id = it.rec_id;
         // age follows the first earlier entry with the same identity
         age = '0;
         found = 1'b0;
         for (int k = 0; k < prior_count; k++) begin
            if (!found && bank_id[pb][k] == id) begin
               found = 1'b1;
               if (bank_age[pb][k] == bota_pkg::AGE_MAX)
                  age = bota_pkg::AGE_MAX;
               else
                  age = bank_age[pb][k] + 1'b1;
            end
         end
         bank_left[cb][fill_count] = it.left;
         bank_top[cb][fill_count] = it.top;
         bank_right[cb][fill_count] = it.right;
         bank_bottom[cb][fill_count] = it.bottom;
         bank_id[cb][fill_count] = id;
         bank_age[cb][fill_count] = age;
         fill_count++;
         trk.identity = id;
         trk.inherited = inh;
         trk.age = age;
         expected_tracks.insert(expected_tracks.size(), trk);
      end
      // frame close swaps the banks
      if (it.frame_end) begin
         prior_count = fill_count;
         fill_count = 0;
         fill_bank = ~fill_bank;
      end
   endfunction

   function automatic logic [CW-1:0] clip(input int v);
      if (v < 0)
         return '0;
      if (v > COORD_MAX)
         return CW'(COORD_MAX);
      return CW'(v);
   endfunction

   function automatic int shake(input int d);
      return int'($urandom_range(0, 2 * d)) - d;
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      return CW'($urandom_range(0, COORD_MAX));
   endfunction

   // mostly "none", some real identities, a few small ones that repeat
   function automatic logic signed [IW-1:0] rand_id();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6)
         return bota_pkg::ID_NONE;
      if (pick < 8)
         return IW'($urandom_range(0, 1023));
      if (pick == 8)
         return IW'($urandom_range(1024, 2047));
      return IW'($urandom_range(0, 7));
   endfunction

   function automatic det_item_type det_box(input int l, input int t, input int r, input int b,
                                            input logic signed [IW-1:0] id, input logic fe);
      det_item_type it;
      it.left = CW'(l);
      it.top = CW'(t);
      it.right = CW'(r);
      it.bottom = CW'(b);
      it.rec_id = id;
      it.has_box = 1'b1;
      it.frame_end = fe;
      return it;
   endfunction

   function automatic det_item_type rand_marker(input logic fe);
      det_item_type it;
      it.left = rand_coord();
      it.top = rand_coord();
      it.right = rand_coord();
      it.bottom = rand_coord();
      it.rec_id = IW'($urandom_range(0, 2047));
      it.has_box = 1'b0;
      it.frame_end = fe;
      return it;
   endfunction

   // new box: mostly a moved copy of a box of the last frame
   function automatic det_item_type make_box();
      det_item_type it;
      det_item_type src;
      int           kind;
      int           d;
      int           l;
      int           t;
      kind = $urandom_range(0, 9);
      it.rec_id = rand_id();
      it.has_box = 1'b1;
      it.frame_end = 1'b0;
      if (kind < 6 && prior_frame.size() != 0) begin
         src = prior_frame[$urandom_range(0, prior_frame.size() - 1)];
         d = $urandom_range(0, 30);
         it.left = clip(int'(src.left) + shake(d));
         it.top = clip(int'(src.top) + shake(d));
         it.right = clip(int'(src.right) + shake(d));
         it.bottom = clip(int'(src.bottom) + shake(d));
      end else if (kind == 6) begin
         it.left = rand_coord();
         it.top = rand_coord();
         it.right = rand_coord();
         it.bottom = rand_coord();
      end else if (kind == 7) begin
         // zero-width box
         l = $urandom_range(0, COORD_MAX);
         it.left = CW'(l);
         it.right = clip(l - int'($urandom_range(0, 3)));
         it.top = rand_coord();
         it.bottom = rand_coord();
      end else begin
         l = $urandom_range(0, COORD_MAX);
         t = $urandom_range(0, COORD_MAX);
         it.left = CW'(l);
         it.top = CW'(t);
         it.right = clip(l + int'($urandom_range(1, 600)));
         it.bottom = clip(t + int'($urandom_range(1, 600)));
      end
      return it;
   endfunction

   // one detection transfer, predicted when accepted
   task automatic send_item(input det_item_type it);
      int gap;
      gap = quiet_mode ? 0 : $urandom_range(0, 9);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_box_left <= it.left;
      req_box_top <= it.top;
      req_box_right <= it.right;
      req_box_bottom <= it.bottom;
      req_recognized_id <= it.rec_id;
      req_has_box <= it.has_box;
      req_frame_end <= it.frame_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_track(it);
   endtask

   task automatic write_enable(input logic value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_enable <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      track_enable = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every pending result, then for markers still in flight
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tracks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // with enable low every item is dropped, frame ends included
   task automatic test_disabled_items();
      det_item_type it;
      drain_results();
      write_enable(1'b0);
      for (int i = 0; i < 8; i++) begin
         it = make_box();
         it.frame_end = 1'(($urandom_range(0, 1)));
         if (i % 3 == 2)
            it.has_box = 1'b0;
         send_item(it);
      end
      drain_results();
      write_enable(1'b1);
   endtask

   task automatic test_directed_cases();
      det_item_type it;
      // first frame: nothing to inherit from
      send_item(det_box(100, 100, 200, 200, 11'sd5, 1'b0));
      send_item(det_box(100, 100, 200, 200, 11'sd9, 1'b0));
      send_item(det_box(50, 50, 50, 80, bota_pkg::ID_NONE, 1'b0));
      send_item(det_box(300, 400, 200, 300, -11'sd1024, 1'b0));
      send_item(det_box(1000, 1000, 1100, 1100, bota_pkg::ID_NONE, 1'b0));
      send_item(det_box(0, 0, 0, 0, 11'sd0, 1'b0));
      send_item(det_box(2000, 2000, 2040, 2040, 11'sd7, 1'b1));
      // tie keeps the earlier box
      send_item(det_box(110, 110, 210, 210, bota_pkg::ID_NONE, 1'b0));
      // overlap exactly a quarter does not inherit; unknown age matches unknown
      send_item(det_box(1050, 1000, 1250, 1100, bota_pkg::ID_NONE, 1'b0));
      // inherits, then recognizer overrides
      send_item(det_box(1000, 1000, 1100, 1100, 11'sd42, 1'b0));
      send_item(det_box(0, 0, COORD_MAX, COORD_MAX, 11'sd1023, 1'b0));
      send_item(det_box(2010, 2010, 2030, 2030, bota_pkg::ID_NONE, 1'b0));
      send_item(rand_marker(1'b0));
      it = '1;
      it.has_box = 1'b0;
      send_item(it);
      // empty frame
      it = '0;
      it.frame_end = 1'b1;
      send_item(it);
      send_item(det_box(110, 110, 210, 210, bota_pkg::ID_NONE, 1'b1));
      send_item(det_box(115, 105, 205, 215, bota_pkg::ID_NONE, 1'b0));
      send_item(det_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, bota_pkg::ID_NONE, 1'b1));
      send_item(rand_marker(1'b1));
      drain_results();
   endtask

   // a frame past capacity, closed by a dropped box, then a full scan
   task automatic test_capacity_full();
      det_item_type it;
      current_frame.delete();
      for (int i = 0; i < CAP + 2; i++) begin
         it = make_box();
         it.frame_end = (i == CAP + 1);
         send_item(it);
         current_frame.insert(current_frame.size(), it);
      end
      prior_frame = current_frame;
      for (int i = 0; i < 3; i++)
         send_item(make_box());
      send_item(rand_marker(1'b1));
      drain_results();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      det_item_type it;
      quiet_mode = 1'b1;
      rsp_hold_len = LONG_HOLD;
      for (int i = 0; i < 20; i++) begin
         it = make_box();
         it.frame_end = (i % 7 == 6);
         send_item(it);
      end
      send_item(rand_marker(1'b1));
      drain_results();
      quiet_mode = 1'b0;
   endtask

   task automatic test_random_frames(input int target);
      det_item_type it;
      int           sent;
      int           nbox;
      sent = 0;
      it = '0;
      while (sent < target) begin
         if ($urandom_range(0, 19) == 0)
            nbox = $urandom_range(CAP - 1, CAP + 2);
         else
            nbox = $urandom_range(0, 6);
         quiet_mode = ($urandom_range(0, 5) == 0);
         current_frame.delete();
         for (int i = 0; i < nbox; i++) begin
            it = make_box();
            it.frame_end = (i == nbox - 1) && ($urandom_range(0, 1) == 1);
            send_item(it);
            current_frame.insert(current_frame.size(), it);
            sent++;
            // stray marker inside the frame
            if ($urandom_range(0, 15) == 0)
               send_item(rand_marker(1'b0));
         end
         if (nbox == 0 || !it.frame_end) begin
            send_item(rand_marker(1'b1));
            sent++;
         end
         prior_frame = current_frame;
      end
      quiet_mode = 1'b0;
   endtask

   // result side: random hold before each transfer, one long hold on request
   initial begin : rsp_side
      int n;
      rsp_stall = 1'b0;
      forever begin
         if (rsp_hold_len > 0) begin
            n = rsp_hold_len;
            rsp_hold_len = 0;
         end else if (quiet_mode) begin
            n = 0;
         end else begin
            n = $urandom_range(0, 9);
         end
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : track_check
      track_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tracks.size() == 0) begin
            log_failure($sformatf("unexpected result: id %0d inherited %0b age %0d",
                                  rsp_identity, rsp_inherited, rsp_age));
         end else begin
            want = expected_tracks.pop_front();
            if (rsp_identity !== want.identity || rsp_inherited !== want.inherited ||
                rsp_age !== want.age)
               log_failure($sformatf({"result mismatch: id exp %0d got %0d, ",
                                      "inherited exp %0b got %0b, age exp %0d got %0d"},
                                     want.identity, rsp_identity, want.inherited,
                                     rsp_inherited, want.age, rsp_age));
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("box_overlap_track_associator regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : main_seq
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_enable = 1'b0;
      req_valid = 1'b0;
      req_box_left = '0;
      req_box_top = '0;
      req_box_right = '0;
      req_box_bottom = '0;
      req_recognized_id = '0;
      req_has_box = 1'b0;
      req_frame_end = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_disabled_items();
      test_directed_cases();
      test_capacity_full();
      test_backpressure();
      test_random_frames(600);
      test_disabled_items();
      test_random_frames(550);

      drain_results();
      if (expected_tracks.size() != 0)
         log_failure("results still outstanding at end of run");
      if (fail_count == 0)
         $display("box_overlap_track_associator regression: pass");
      else
         $display("box_overlap_track_associator regression: fail");
      $finish;
   end

endmodule
